### design/assert_macros.svh
// Assertion macros for the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk_i, off while rst_ni is low
`define ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/mwu_pkg.sv
// Types, codes and helpers shared by the momentum weight update block.
`timescale 1ns / 1ps

package mwu_pkg;

  // Item operation codes
  typedef enum logic [2:0] {
    OP_WRITE_WEIGHT = 3'd0,
    OP_WRITE_LAYER  = 3'd1,
    OP_WRITE_DELTA  = 3'd2,
    OP_UPDATE       = 3'd3,
    OP_READ_WEIGHT  = 3'd4
  } op_e;

  // Configuration register indexes (word address)
  typedef enum logic [1:0] {
    REG_LEARNING_RATE   = 2'd0,
    REG_MOMENTUM_FACTOR = 2'd1,
    REG_ROWS_IN_USE     = 2'd2,
    REG_COLS_IN_USE     = 2'd3
  } reg_e;

  localparam int DataW = 32;
  localparam int FracW = 16;
  localparam int SumW  = 50;

  // Write-back from the arithmetic pipeline to the matrix memory
  typedef struct packed {
    logic             valid;
    logic             sat;
    logic [DataW-1:0] weight;
    logic [DataW-1:0] change;
  } wb_t;

  // Saturate a wide signed value to 32 bits; MSB of the result flags a clip
  function automatic logic [DataW:0] clip_q16(input logic signed [SumW-1:0] x);
    logic [DataW:0] r;
    if (x[SumW-1:DataW-1] != {(SumW-DataW+1){x[SumW-1]}}) begin
      r = x[SumW-1] ? {1'b1, 1'b1, {(DataW-1){1'b0}}} : {1'b1, 1'b0, {(DataW-1){1'b1}}};
    end else begin
      r = {1'b0, x[DataW-1:0]};
    end
    return r;
  endfunction

endpackage

### design/mwu_ram.sv
// Simple dual-port synchronous RAM with registered read data.
`timescale 1ns / 1ps

module mwu_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // read port, registered read data
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### design/mwu_mac_pipe.sv
// Five-stage fixed-point pipeline: change = eta*delta*layer + momentum*old, weight += change.
`timescale 1ns / 1ps

module mwu_mac_pipe #(
  parameter int AW = 12
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [AW-1:0]      addr_i,
  input  logic signed [31:0] delta_i,
  input  logic signed [31:0] layer_i,
  input  logic signed [31:0] weight_i,
  input  logic signed [31:0] change_i,
  input  logic [15:0]        eta_i,
  input  logic [15:0]        mom_i,
  output logic [AW-1:0]      out_addr_o,
  output mwu_pkg::wb_t       wb_o,
  output logic               busy_o
);

  logic v1_q, v2_q, v3_q, v4_q, v5_q;
  logic [AW-1:0] a1_q, a2_q, a3_q, a4_q, a5_q;
  logic signed [31:0] w1_q, w2_q, w3_q, w4_q;

  // stage 1: delta*layer and old_change*momentum, both floored by 2^16
  logic signed [63:0] dl_prod;
  logic signed [48:0] cm_prod;
  logic signed [47:0] p1_q;
  logic signed [31:0] b1_q;

  assign dl_prod = delta_i * layer_i;
  assign cm_prod = change_i * $signed({1'b0, mom_i});

  always_ff @(posedge clk_i) begin
    p1_q <= dl_prod[63:16];
    b1_q <= cm_prod[47:16];
    w1_q <= weight_i;
    a1_q <= addr_i;
  end

  // stage 2: p*eta split as high word times eta plus low fraction times eta
  logic signed [48:0] ahi_prod;
  logic [31:0] alo_prod;
  logic signed [48:0] ahi2_q;
  logic [15:0] alo2_q;
  logic signed [31:0] b2_q;

  assign ahi_prod = $signed(p1_q[47:16]) * $signed({1'b0, eta_i});
  assign alo_prod = p1_q[15:0] * eta_i;

  always_ff @(posedge clk_i) begin
    ahi2_q <= ahi_prod;
    alo2_q <= alo_prod[31:16];
    b2_q   <= b1_q;
    w2_q   <= w1_q;
    a2_q   <= a1_q;
  end

  // stage 3: a + b
  logic signed [49:0] s3_d;
  logic signed [49:0] s3_q;

  assign s3_d = $signed({ahi2_q[48], ahi2_q}) + $signed({34'b0, alo2_q})
              + $signed({{18{b2_q[31]}}, b2_q});

  always_ff @(posedge clk_i) begin
    s3_q <= s3_d;
    w3_q <= w2_q;
    a3_q <= a2_q;
  end

  // stage 4: clip the change
  logic [32:0] ch_clip;
  logic signed [31:0] ch4_q;
  logic sat4_q;

  assign ch_clip = mwu_pkg::clip_q16(s3_q);

  always_ff @(posedge clk_i) begin
    ch4_q  <= ch_clip[31:0];
    sat4_q <= ch_clip[32];
    w4_q   <= w3_q;
    a4_q   <= a3_q;
  end

  // stage 5: weight + change, clipped, into the write-back register
  logic signed [49:0] wsum;
  logic [32:0] w_clip;
  logic [31:0] wnew5_q, ch5_q;
  logic sat5_q;

  assign wsum = $signed({{18{w4_q[31]}}, w4_q}) + $signed({{18{ch4_q[31]}}, ch4_q});
  assign w_clip = mwu_pkg::clip_q16(wsum);

  always_ff @(posedge clk_i) begin
    wnew5_q <= w_clip[31:0];
    ch5_q   <= ch4_q;
    sat5_q  <= sat4_q | w_clip[32];
    a5_q    <= a4_q;
  end

  // valid chain
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
    end else begin
      v1_q <= in_valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      v5_q <= v4_q;
    end
  end

  assign wb_o.valid  = v5_q;
  assign wb_o.sat    = sat5_q;
  assign wb_o.weight = wnew5_q;
  assign wb_o.change = ch5_q;
  assign out_addr_o  = a5_q;
  assign busy_o      = v1_q | v2_q | v3_q | v4_q | v5_q;

endmodule

### design/momentum_weight_update.sv
// Top level of the SGD-with-momentum weight update engine.
//
// Usage:
//   Items enter on start/operation_i/row_index_i/col_index_i/data_value_i and
//   are accepted when start is high and busy is low. Every item gives one
//   result on weight_out_o/change_out_o/saturated_o, marked by done_o for one
//   cycle; the receiver has to take it then, it cannot stall the block.
//   Weight, layer and delta writes and weight reads give their result the
//   cycle after acceptance, and while busy is low a new item may be accepted
//   every cycle. An update walks every in-use entry, one matrix entry per
//   cycle through the read-modify-write path of the matrix memory (no entry
//   when either size is zero); busy stays high until the last write-back is
//   in the matrix memory, and done_o rises at the same edge that drops busy.
//   The arithmetic is a five-stage pipeline behind the memory read. The APB
//   port sets eta, momentum and the sizes; write it only while the block is
//   idle. Reset clears control, sets eta and momentum to zero and both sizes
//   to 64; memories keep their contents and are undefined until written.
`timescale 1ns / 1ps

module momentum_weight_update #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // items
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  operation_i,
  input  logic [5:0]  row_index_i,
  input  logic [5:0]  col_index_i,
  input  logic signed [31:0] data_value_i,
  // results
  output logic        done_o,
  output logic signed [31:0] weight_out_o,
  output logic signed [31:0] change_out_o,
  output logic        saturated_o
);

  localparam int RW  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW  = (MAX_ROWS * MAX_COLS > 1) ? $clog2(MAX_ROWS * MAX_COLS) : 1;
  localparam int NRW = ($clog2(MAX_ROWS + 1) > 7) ? $clog2(MAX_ROWS + 1) : 7;
  localparam int NCW = ($clog2(MAX_COLS + 1) > 7) ? $clog2(MAX_COLS + 1) : 7;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WALK,
    ST_DRAIN
  } state_e;

  // ---------------- configuration registers
  logic [15:0] learning_rate_q, momentum_factor_q;
  logic [6:0]  rows_in_use_q, cols_in_use_q;
  logic        cfg_we;

  assign cfg_we = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      learning_rate_q   <= 16'd0;
      momentum_factor_q <= 16'd0;
      rows_in_use_q     <= 7'd64;
      cols_in_use_q     <= 7'd64;
    end else if (cfg_we) begin
      case (paddr[3:2])
        mwu_pkg::REG_LEARNING_RATE:   learning_rate_q   <= pwdata[15:0];
        mwu_pkg::REG_MOMENTUM_FACTOR: momentum_factor_q <= pwdata[15:0];
        mwu_pkg::REG_ROWS_IN_USE:     rows_in_use_q     <= pwdata[6:0];
        mwu_pkg::REG_COLS_IN_USE:     cols_in_use_q     <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      mwu_pkg::REG_LEARNING_RATE:   prdata = {16'd0, learning_rate_q};
      mwu_pkg::REG_MOMENTUM_FACTOR: prdata = {16'd0, momentum_factor_q};
      mwu_pkg::REG_ROWS_IN_USE:     prdata = {25'd0, rows_in_use_q};
      mwu_pkg::REG_COLS_IN_USE:     prdata = {25'd0, cols_in_use_q};
      default:                      prdata = 32'd0;
    endcase
  end

  // ---------------- item decode
  logic accept, row_ok, col_ok;
  logic is_update, is_wr_weight, is_wr_layer, is_wr_delta, is_read;
  logic [AW-1:0] in_addr;

  assign accept       = start & ~busy;
  assign row_ok       = 32'(row_index_i) < MAX_ROWS;
  assign col_ok       = 32'(col_index_i) < MAX_COLS;
  assign is_update    = operation_i == mwu_pkg::OP_UPDATE;
  assign is_wr_weight = operation_i == mwu_pkg::OP_WRITE_WEIGHT;
  assign is_wr_layer  = operation_i == mwu_pkg::OP_WRITE_LAYER;
  assign is_wr_delta  = operation_i == mwu_pkg::OP_WRITE_DELTA;
  assign is_read      = operation_i == mwu_pkg::OP_READ_WEIGHT;
  assign in_addr      = AW'(32'(row_index_i) * MAX_COLS + 32'(col_index_i));

  // ---------------- walk sequencer signals
  state_e state_q;
  logic [RW-1:0] row_q;
  logic [CW-1:0] col_q;
  logic [NRW-1:0] rows_eff;
  logic [NCW-1:0] cols_eff;
  logic last_row, last_col, walking;
  logic [AW-1:0] walk_addr, walk_addr_q;
  logic issue_q;

  assign rows_eff = (NRW'(rows_in_use_q) > NRW'(MAX_ROWS)) ? NRW'(MAX_ROWS)
                                                           : NRW'(rows_in_use_q);
  assign cols_eff = (NCW'(cols_in_use_q) > NCW'(MAX_COLS)) ? NCW'(MAX_COLS)
                                                           : NCW'(cols_in_use_q);
  assign last_row  = (NRW'(row_q) + NRW'(1)) == rows_eff;
  assign last_col  = (NCW'(col_q) + NCW'(1)) == cols_eff;
  assign walking   = state_q == ST_WALK;
  assign walk_addr = AW'(32'(row_q) * MAX_COLS + 32'(col_q));
  assign busy      = state_q != ST_IDLE;

  // ---------------- memories
  mwu_pkg::wb_t  wb;
  logic [AW-1:0] wb_addr;
  logic          pipe_busy;
  logic [63:0]   mat_rdata, mat_wdata;
  logic [AW-1:0] mat_waddr, mat_raddr;
  logic          mat_we;
  logic [31:0]   layer_rdata, delta_rdata;

  assign mat_we    = wb.valid | (accept & is_wr_weight & row_ok & col_ok);
  assign mat_waddr = wb.valid ? wb_addr : in_addr;
  assign mat_wdata = wb.valid ? {wb.weight, wb.change} : {data_value_i, 32'd0};
  assign mat_raddr = walking ? walk_addr : in_addr;

  // weight in the upper word, stored change in the lower word
  mwu_ram #(
    .DEPTH(MAX_ROWS * MAX_COLS),
    .WIDTH(64)
  ) u_matrix (
    .clk_i  (clk_i),
    .we_i   (mat_we),
    .waddr_i(mat_waddr),
    .wdata_i(mat_wdata),
    .raddr_i(mat_raddr),
    .rdata_o(mat_rdata)
  );

  mwu_ram #(
    .DEPTH(MAX_ROWS),
    .WIDTH(32)
  ) u_layer (
    .clk_i  (clk_i),
    .we_i   (accept & is_wr_layer & row_ok),
    .waddr_i(RW'(row_index_i)),
    .wdata_i(data_value_i),
    .raddr_i(row_q),
    .rdata_o(layer_rdata)
  );

  mwu_ram #(
    .DEPTH(MAX_COLS),
    .WIDTH(32)
  ) u_delta (
    .clk_i  (clk_i),
    .we_i   (accept & is_wr_delta & col_ok),
    .waddr_i(CW'(col_index_i)),
    .wdata_i(data_value_i),
    .raddr_i(col_q),
    .rdata_o(delta_rdata)
  );

  // ---------------- arithmetic pipeline
  mwu_mac_pipe #(
    .AW(AW)
  ) u_pipe (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(issue_q),
    .addr_i    (walk_addr_q),
    .delta_i   (delta_rdata),
    .layer_i   (layer_rdata),
    .weight_i  (mat_rdata[63:32]),
    .change_i  (mat_rdata[31:0]),
    .eta_i     (learning_rate_q),
    .mom_i     (momentum_factor_q),
    .out_addr_o(wb_addr),
    .wb_o      (wb),
    .busy_o    (pipe_busy)
  );

  // issue marker travels with the memory read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      issue_q <= 1'b0;
    end else begin
      issue_q <= walking;
    end
  end

  always_ff @(posedge clk_i) begin
    walk_addr_q <= walk_addr;
  end

  // saturation seen during the current update
  logic sat_acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_acc_q <= 1'b0;
    end else if (accept && is_update) begin
      sat_acc_q <= 1'b0;
    end else if (wb.valid && wb.sat) begin
      sat_acc_q <= 1'b1;
    end
  end

  // ---------------- sequencer and result registers
  logic done_q, rd_ok_q, sat_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      done_q  <= 1'b0;
      rd_ok_q <= 1'b0;
      sat_q   <= 1'b0;
    end else begin
      done_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (is_update) begin
              row_q <= '0;
              col_q <= '0;
              if (rows_eff != '0 && cols_eff != '0) begin
                state_q <= ST_WALK;
              end else begin
                state_q <= ST_DRAIN;
              end
            end else begin
              done_q  <= 1'b1;
              rd_ok_q <= is_read & row_ok & col_ok;
              sat_q   <= 1'b0;
            end
          end
        end
        ST_WALK: begin
          if (last_row) begin
            row_q <= '0;
            if (last_col) begin
              state_q <= ST_DRAIN;
            end else begin
              col_q <= col_q + CW'(1);
            end
          end else begin
            row_q <= row_q + RW'(1);
          end
        end
        ST_DRAIN: begin
          if (!issue_q && !pipe_busy) begin
            state_q <= ST_IDLE;
            done_q  <= 1'b1;
            rd_ok_q <= 1'b0;
            sat_q   <= sat_acc_q;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign done_o       = done_q;
  assign weight_out_o = rd_ok_q ? mat_rdata[63:32] : 32'd0;
  assign change_out_o = rd_ok_q ? mat_rdata[31:0] : 32'd0;
  assign saturated_o  = sat_q;

endmodule

### design/mwu_checker.sv
// Port-level checker for the momentum weight update block, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module mwu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [2:0]  operation_i,
  input logic        done_o,
  input logic [31:0] weight_out_o,
  input logic [31:0] change_out_o,
  input logic        saturated_o
);

  // accepted item that is not an update, and a result with no data
  logic short_item, quiet_out;

  assign short_item = start && !busy && (operation_i != mwu_pkg::OP_UPDATE);
  assign quiet_out  = (weight_out_o == 32'd0) && (change_out_o == 32'd0);

  // any item other than an update answers in the very next cycle
  `ASSERT_NEXT(a_short_item_done, short_item, done_o)

  // an update item holds the block busy
  `ASSERT_NEXT(a_update_busy, start && !busy && (operation_i == mwu_pkg::OP_UPDATE), busy)

  // end of an update walk always comes with its result
  `ASSERT_IMP(a_update_result, $fell(busy), done_o)

  // only reads carry data: loads and unknown codes answer with zero words; a saturation flag never comes with read data
  `ASSERT_NEXT(a_no_data_off_read, short_item && (operation_i != mwu_pkg::OP_READ_WEIGHT), quiet_out)
  `ASSERT_IMP(a_sat_only_update, done_o && saturated_o, quiet_out)

endmodule

bind momentum_weight_update mwu_checker u_mwu_checker (.*);

### tb/tb_top.sv
// Self-checking testbench for the momentum weight update engine.
`timescale 1ns / 1ps

module tb_top;

  localparam int NumRows = 64;
  localparam int NumCols = 64;
  localparam int BlockN  = 8;   // dense corner block of defined weights
  localparam logic [2:0] OpFirstUnknown = 3'(mwu_pkg::OP_READ_WEIGHT) + 3'd1;
  localparam logic [2:0] OpLastCode = '1;
  localparam longint WordMax = 64'sd2147483647;
  localparam longint WordMin = -64'sd2147483648;

  typedef struct {
    logic [2:0]         op;
    logic [5:0]         row;
    logic [5:0]         col;
    logic signed [31:0] data;
    bit                 drain_first;  // hold until all results are back
  } weight_cmd_t;

  typedef struct {
    logic [2:0]         op;
    logic signed [31:0] weight;
    logic signed [31:0] change;
    logic               sat;
  } weight_result_t;

  // DUT signals
  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [3:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               start = 1'b0;
  logic               busy;
  logic [2:0]         operation_i = '0;
  logic [5:0]         row_index_i = '0;
  logic [5:0]         col_index_i = '0;
  logic signed [31:0] data_value_i = '0;
  logic               done_o;
  logic signed [31:0] weight_out_o;
  logic signed [31:0] change_out_o;
  logic               saturated_o;

  // Shadow copy of the block state and its registers
  logic signed [31:0] shadow_weight [NumRows][NumCols];
  logic signed [31:0] shadow_change [NumRows][NumCols];
  logic signed [31:0] shadow_layer [NumRows];
  logic signed [31:0] shadow_delta [NumCols];
  logic [15:0]        shadow_eta = '0;
  logic [15:0]        shadow_momentum = '0;
  logic [6:0]         shadow_rows = 7'd64;
  logic [6:0]         shadow_cols = 7'd64;

  weight_cmd_t    cmd_backlog [$];
  weight_result_t expected_results [$];
  weight_cmd_t    live_cmd;
  int             idle_pct = 0;
  int             planned_cmds = 0;
  int             cmds_accepted = 0;
  int             results_checked = 0;
  int             updates_checked = 0;
  int             clipped_updates = 0;
  int             reads_checked = 0;
  int             bad_results = 0;

  momentum_weight_update u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .operation_i  (operation_i),
    .row_index_i  (row_index_i),
    .col_index_i  (col_index_i),
    .data_value_i (data_value_i),
    .done_o       (done_o),
    .weight_out_o (weight_out_o),
    .change_out_o (change_out_o),
    .saturated_o  (saturated_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Saturate to signed 32 bits, flag any clip
  function automatic logic signed [31:0] clip_q16_16(input longint x, inout logic clipped);
    if (x > WordMax) begin
      clipped = 1'b1;
      return WordMax[31:0];
    end
    if (x < WordMin) begin
      clipped = 1'b1;
      return WordMin[31:0];
    end
    return x[31:0];
  endfunction

  // Apply one item to the shadow state and return the result it should give
  function automatic weight_result_t predict_weight_item(input weight_cmd_t cmd);
    weight_result_t res;
    int unsigned nr, nc;
    longint prod, eta_part, mom_part;
    logic signed [31:0] chg;
    logic clipped;
    res.op = cmd.op;
    res.weight = '0;
    res.change = '0;
    clipped = 1'b0;
    case (cmd.op)
      mwu_pkg::OP_WRITE_WEIGHT: begin
        shadow_weight[cmd.row][cmd.col] = cmd.data;
        shadow_change[cmd.row][cmd.col] = '0;
      end
      mwu_pkg::OP_WRITE_LAYER: shadow_layer[cmd.row] = cmd.data;
      mwu_pkg::OP_WRITE_DELTA: shadow_delta[cmd.col] = cmd.data;
      mwu_pkg::OP_UPDATE: begin
        nr = (shadow_rows > NumRows) ? NumRows : shadow_rows;
        nc = (shadow_cols > NumCols) ? NumCols : shadow_cols;
        for (int c = 0; c < nc; c++) begin
          for (int r = 0; r < nr; r++) begin
            // all shifts floor toward minus infinity
            prod = (longint'(shadow_delta[c]) * longint'(shadow_layer[r])) >>> mwu_pkg::FracW;
            eta_part = (prod * longint'(shadow_eta)) >>> mwu_pkg::FracW;
            mom_part = (longint'(shadow_change[r][c]) * longint'(shadow_momentum))
                       >>> mwu_pkg::FracW;
            chg = clip_q16_16(eta_part + mom_part, clipped);
            shadow_weight[r][c] =
              clip_q16_16(longint'(shadow_weight[r][c]) + longint'(chg), clipped);
            shadow_change[r][c] = chg;
          end
        end
      end
      mwu_pkg::OP_READ_WEIGHT: begin
        res.weight = shadow_weight[cmd.row][cmd.col];
        res.change = shadow_change[cmd.row][cmd.col];
      end
      default: ;
    endcase
    res.sat = clipped;
    return res;
  endfunction

  // Item driver: present the next queued item, count it in at acceptance
  always @(posedge clk_i) begin : cmd_driver
    bit taken, free_slot;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken = start && !busy;
      if (taken) begin
        expected_results.push_back(predict_weight_item(live_cmd));
        cmds_accepted++;
      end
      free_slot = !start || taken;
      if (free_slot) begin
        if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct &&
            (!cmd_backlog[0].drain_first || expected_results.size() == 0)) begin
          live_cmd = cmd_backlog.pop_front();
          operation_i  <= live_cmd.op;
          row_index_i  <= live_cmd.row;
          col_index_i  <= live_cmd.col;
          data_value_i <= live_cmd.data;
          start        <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  task automatic check_word(input string what, input logic [31:0] want,
                            input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, what, want, got);
      bad_results++;
    end
  endtask

  // Result monitor: every strobe is matched against the oldest prediction
  always @(posedge clk_i) begin : result_monitor
    weight_result_t oldest;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, weight %h change %h sat %b",
                 $time, weight_out_o, change_out_o, saturated_o);
        bad_results++;
      end else begin
        oldest = expected_results.pop_front();
        check_word("weight_out", oldest.weight, weight_out_o);
        check_word("change_out", oldest.change, change_out_o);
        check_word("saturated", {31'd0, oldest.sat}, {31'd0, saturated_o});
        results_checked++;
        if (oldest.op == mwu_pkg::OP_UPDATE) begin
          updates_checked++;
          if (oldest.sat) clipped_updates++;
        end
        if (oldest.op == mwu_pkg::OP_READ_WEIGHT) reads_checked++;
      end
    end
  end

  // Register write, then read back; the shadow copy keeps the masked value
  task automatic write_config(input mwu_pkg::reg_e idx, input logic [31:0] value);
    logic [31:0] kept;
    case (idx)
      mwu_pkg::REG_LEARNING_RATE: begin
        kept = {16'd0, value[15:0]};
        shadow_eta = value[15:0];
      end
      mwu_pkg::REG_MOMENTUM_FACTOR: begin
        kept = {16'd0, value[15:0]};
        shadow_momentum = value[15:0];
      end
      mwu_pkg::REG_ROWS_IN_USE: begin
        kept = {25'd0, value[6:0]};
        shadow_rows = value[6:0];
      end
      default: begin
        kept = {25'd0, value[6:0]};
        shadow_cols = value[6:0];
      end
    endcase
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== kept) begin
      $display("%0t: register %s readback, expected %h, got %h",
               $time, idx.name(), kept, prdata);
      bad_results++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic wait_drained();
    do @(negedge clk_i);
    while (cmd_backlog.size() != 0 || start || expected_results.size() != 0);
  endtask

  function automatic void queue_cmd(input logic [2:0] op, input int row, input int col,
                                    input logic signed [31:0] data, input bit drain = 1'b0);
    weight_cmd_t cmd;
    cmd.op = op;
    cmd.row = 6'(row);
    cmd.col = 6'(col);
    cmd.data = data;
    cmd.drain_first = drain;
    cmd_backlog.push_back(cmd);
    planned_cmds++;
  endfunction

  // Pick a weight entry that the fill pass has written: the corner block,
  // the first column or the first row
  function automatic void pick_filled(output int r, output int c);
    case ($urandom_range(2))
      0: begin
        r = $urandom_range(BlockN - 1);
        c = $urandom_range(BlockN - 1);
      end
      1: begin
        r = $urandom_range(NumRows - 1);
        c = 0;
      end
      default: begin
        r = 0;
        c = $urandom_range(NumCols - 1);
      end
    endcase
  endfunction

  // Mostly small Q16.16 values, some full-range and some extremes
  function automatic logic signed [31:0] rand_q16();
    case ($urandom_range(9))
      0: begin
        case ($urandom_range(3))
          0: return 32'sh7FFF_FFFF;
          1: return 32'sh8000_0000;
          2: return 32'sh0;
          default: return -32'sd1;
        endcase
      end
      1, 2: return $urandom;
      default: return $signed($urandom_range(32'h0008_0000)) - 32'sh0004_0000;
    endcase
  endfunction

  // Training steps (fresh layer/delta values, update, read back) plus noise
  task automatic plan_random_phase(input int n_cmds);
    int span_r, span_c, first, k, pr, pc;
    span_r = (shadow_rows == 0) ? 1 : ((shadow_rows > NumRows) ? NumRows : shadow_rows);
    span_c = (shadow_cols == 0) ? 1 : ((shadow_cols > NumCols) ? NumCols : shadow_cols);
    first = planned_cmds;
    while (planned_cmds - first < n_cmds) begin
      if ($urandom_range(9) < 7) begin
        k = $urandom_range(1, 4);
        repeat (k) queue_cmd(mwu_pkg::OP_WRITE_LAYER, $urandom_range(span_r - 1),
                             $urandom_range(63), rand_q16());
        repeat (k) queue_cmd(mwu_pkg::OP_WRITE_DELTA, $urandom_range(63),
                             $urandom_range(span_c - 1), rand_q16());
        if ($urandom_range(3) == 0)
          queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, $urandom_range(span_r - 1),
                    $urandom_range(span_c - 1), rand_q16());
        queue_cmd(mwu_pkg::OP_UPDATE, $urandom_range(63), $urandom_range(63), $urandom,
                  $urandom_range(7) == 0);
        repeat ($urandom_range(1, 3))
          queue_cmd(mwu_pkg::OP_READ_WEIGHT, $urandom_range(span_r - 1),
                    $urandom_range(span_c - 1), $urandom, $urandom_range(15) == 0);
      end else begin
        pick_filled(pr, pc);
        case ($urandom_range(5))
          0: queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, pr, pc, rand_q16());
          1: queue_cmd(mwu_pkg::OP_WRITE_LAYER, $urandom_range(63), $urandom_range(63),
                       rand_q16());
          2: queue_cmd(mwu_pkg::OP_WRITE_DELTA, $urandom_range(63), $urandom_range(63),
                       rand_q16());
          3: queue_cmd(mwu_pkg::OP_READ_WEIGHT, pr, pc, $urandom);
          4: queue_cmd(3'($urandom_range(OpLastCode, OpFirstUnknown)), $urandom_range(63),
                       $urandom_range(63), $urandom);
          default: queue_cmd(mwu_pkg::OP_UPDATE, $urandom_range(63), $urandom_range(63),
                             $urandom);
        endcase
      end
    end
  endtask

  initial begin : main_sequence
    logic [15:0] eta_pick, mom_pick;
    logic [6:0]  rows_pick, cols_pick;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: single-entry updates so only written entries are touched
    write_config(mwu_pkg::REG_LEARNING_RATE, 32'h0000_8000);
    write_config(mwu_pkg::REG_MOMENTUM_FACTOR, 32'h0000_4000);
    write_config(mwu_pkg::REG_ROWS_IN_USE, 32'd1);
    write_config(mwu_pkg::REG_COLS_IN_USE, 32'd1);
    queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, 0, 0, 32'sh0001_0000);
    queue_cmd(mwu_pkg::OP_WRITE_LAYER, 0, 0, 32'sh0002_0000);
    queue_cmd(mwu_pkg::OP_WRITE_DELTA, 0, 0, -32'sh0001_0000);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 0, 0, 32'sh0);
    queue_cmd(mwu_pkg::OP_UPDATE, 0, 0, 32'sh0);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 0, 0, 32'sh0, 1'b1);
    queue_cmd(mwu_pkg::OP_UPDATE, 63, 63, -32'sd1);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 0, 0, 32'sh0);
    queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, 63, 63, 32'sh8000_0000);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 63, 63, 32'sh0);
    // largest weight plus a large positive change clips both
    queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, 0, 0, 32'sh7FFF_FFFF);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 0, 0, 32'sh0);
    queue_cmd(mwu_pkg::OP_WRITE_LAYER, 0, 63, 32'sh7FFF_FFFF);
    queue_cmd(mwu_pkg::OP_WRITE_DELTA, 63, 0, 32'sh7FFF_FFFF);
    queue_cmd(mwu_pkg::OP_UPDATE, 0, 0, 32'sh0);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 0, 0, 32'sh0);
    // most negative delta drives the change to the negative limit
    queue_cmd(mwu_pkg::OP_WRITE_DELTA, 0, 0, 32'sh8000_0000);
    queue_cmd(mwu_pkg::OP_UPDATE, 0, 0, 32'sh0);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 0, 0, 32'sh0);
    // unknown codes answer zero and change nothing
    queue_cmd(OpFirstUnknown, 0, 0, 32'sh7FFF_FFFF);
    queue_cmd(OpFirstUnknown + 3'd1, 63, 63, 32'sh8000_0000);
    queue_cmd(OpLastCode, $urandom_range(63), $urandom_range(63), $urandom);
    queue_cmd(mwu_pkg::OP_WRITE_LAYER, 63, 0, 32'sh7FFF_FFFF);
    queue_cmd(mwu_pkg::OP_WRITE_DELTA, 0, 63, 32'sh8000_0000);
    queue_cmd(mwu_pkg::OP_READ_WEIGHT, 63, 63, 32'sh0);
    wait_drained();

    // fill the corner block, the first column, the first row and both vectors
    idle_pct = 13;
    for (int r = 0; r < BlockN; r++)
      for (int c = 0; c < BlockN; c++)
        queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, r, c, rand_q16());
    for (int r = BlockN; r < NumRows; r++)
      queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, r, 0, rand_q16());
    for (int c = BlockN; c < NumCols; c++)
      queue_cmd(mwu_pkg::OP_WRITE_WEIGHT, 0, c, rand_q16());
    for (int i = 0; i < NumRows; i++) begin
      queue_cmd(mwu_pkg::OP_WRITE_LAYER, i, $urandom_range(63), rand_q16());
      queue_cmd(mwu_pkg::OP_WRITE_DELTA, $urandom_range(63), i, rand_q16());
    end
    wait_drained();

    // random phases, each with its own register setting and idle rate;
    // every update stays inside the filled entries
    for (int ph = 0; ph < 10; ph++) begin
      eta_pick  = $urandom;
      mom_pick  = $urandom;
      rows_pick = 7'($urandom_range(1, BlockN));
      cols_pick = 7'($urandom_range(1, BlockN));
      case (ph)
        0: begin
          eta_pick  = '1;
          mom_pick  = '1;
          rows_pick = 7'd64;
          cols_pick = 7'd1;
        end
        1: begin
          eta_pick  = '0;
          mom_pick  = '0;
          rows_pick = 7'd1;
          cols_pick = 7'd1;
        end
        2: rows_pick = 7'd0;
        3: begin
          // a row count above the matrix clamps to the full height
          rows_pick = '1;
          cols_pick = 7'd1;
        end
        4: cols_pick = 7'd0;
        5: begin
          rows_pick = 7'd1;
          cols_pick = 7'd64;
        end
        6: begin
          // a column count above the matrix clamps to the full width
          rows_pick = 7'd1;
          cols_pick = '1;
        end
        default: ;
      endcase
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 45;
        default: idle_pct = 13;
      endcase
      write_config(mwu_pkg::REG_LEARNING_RATE, {16'($urandom), eta_pick});
      write_config(mwu_pkg::REG_MOMENTUM_FACTOR, {16'($urandom), mom_pick});
      write_config(mwu_pkg::REG_ROWS_IN_USE, {25'($urandom), rows_pick});
      write_config(mwu_pkg::REG_COLS_IN_USE, {25'($urandom), cols_pick});
      plan_random_phase(25);
      wait_drained();
    end

    repeat (20) @(posedge clk_i);
    $display("summary: %0d items in, %0d results checked, %0d reads", cmds_accepted,
             results_checked, reads_checked);
    $display("summary: %0d updates over 10 register settings, %0d of them clipped",
             updates_checked, clipped_updates);
    if (bad_results == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  // Hard stop well past the slowest correct run
  initial begin : run_limit
    #5_000_000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

### files.f
+incdir+design
design/mwu_pkg.sv
design/mwu_ram.sv
design/mwu_mac_pipe.sv
design/momentum_weight_update.sv
design/mwu_checker.sv
tb/tb_top.sv
